FILE: rtl/core/irwn_pkg.sv
// Shared types and constants of the infrared window normalizer.
// Holds the beat structs, the lane control struct and the register indexes.
// No dependencies.
package irwn_pkg;

    localparam int CH_N       = 4;
    localparam int SAMPLE_W   = 12;
    localparam int DIFF_W     = SAMPLE_W + 1;
    localparam int SCALE_W    = 30;
    localparam int NORM_W     = 24;
    localparam int PROD_W     = DIFF_W + SCALE_W;
    localparam int FRAC_SHIFT = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = SCALE_W;

    localparam int WINDOW_DEF = 16;
    localparam int WINDOW_MAX = 64;
    localparam int SLOT_MAX_W = $clog2(WINDOW_MAX);

    // Register stages from the input register up to the result register.
    localparam int STAGES = 7;

    localparam logic signed [NORM_W-1:0] NORM_MAX = 24'sh7FFFFF;
    localparam logic signed [NORM_W-1:0] NORM_MIN = 24'sh800000;

    localparam logic [SCALE_W-1:0] SCALE_RESET = 30'd65536;

    localparam logic [CFG_IDX_W-1:0] REG_BASE_LF  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_L   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_R   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_RF  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_LF = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_L  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_R  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_RF = 3'd7;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample_lf;
        logic [SAMPLE_W-1:0] sample_l;
        logic [SAMPLE_W-1:0] sample_r;
        logic [SAMPLE_W-1:0] sample_rf;
    } t_in_beat;

    typedef struct packed {
        logic signed [NORM_W-1:0] norm_lf;
        logic signed [NORM_W-1:0] norm_l;
        logic signed [NORM_W-1:0] norm_r;
        logic signed [NORM_W-1:0] norm_rf;
        logic signed [NORM_W-1:0] avg_norm_lf;
        logic signed [NORM_W-1:0] avg_norm_l;
        logic signed [NORM_W-1:0] avg_norm_r;
        logic signed [NORM_W-1:0] avg_norm_rf;
        logic [SAMPLE_W-1:0]      avg_raw_lf;
        logic [SAMPLE_W-1:0]      avg_raw_l;
        logic [SAMPLE_W-1:0]      avg_raw_r;
        logic [SAMPLE_W-1:0]      avg_raw_rf;
    } t_out_beat;

    // ld[k] loads stage k at the coming edge. The slot and fill flags belong
    // to the item that sits in the named stage.
    typedef struct packed {
        logic [STAGES:1]         ld;
        logic [SLOT_MAX_W-1:0]   slot1;
        logic                    full2;
        logic [SLOT_MAX_W-1:0]   slot3;
        logic                    full4;
    } t_lane_ctl;

endpackage

FILE: rtl/core/irwn_ctrl.sv
// Pipeline control of the infrared window normalizer: stage valid bits,
// per-stage load enables, ring slot counter and warm-up fill count.
// Depends on irwn_pkg.
module irwn_ctrl import irwn_pkg::*; #(
    parameter int WINDOW = WINDOW_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  logic      i_out_stall,
    output logic      o_out_valid,
    output t_lane_ctl o_ctl
);

    localparam int SLOT_W = $clog2(WINDOW);
    localparam int FILL_W = $clog2(WINDOW + 1);

    logic [STAGES:1]   r_vld;
    logic [STAGES:1]   n_vld;
    logic [STAGES:1]   mv;
    logic [STAGES:1]   ld;
    logic              accept;
    logic [SLOT_W-1:0] r_slot;
    logic [SLOT_W-1:0] n_slot;
    logic [FILL_W-1:0] r_fill;
    logic [SLOT_W-1:0] r_slot1;
    logic [SLOT_W-1:0] r_slot2;
    logic [SLOT_W-1:0] r_slot3;
    logic              r_full1;
    logic              r_full2;
    logic              r_full3;
    logic              r_full4;

    // A stage moves on when it holds a beat and the next stage is empty or
    // moving too, so bubbles close up behind a stalled result.
    always_comb begin
        mv[STAGES] = r_vld[STAGES] && !i_out_stall;
        for (int k = STAGES - 1; k >= 1; k--) begin
            mv[k] = r_vld[k] && (!r_vld[k+1] || mv[k+1]);
        end
        accept = i_in_valid && (!r_vld[1] || mv[1]);
        ld[1]  = accept;
        for (int k = 2; k <= STAGES; k++) begin
            ld[k] = mv[k-1];
        end
        for (int k = 1; k <= STAGES; k++) begin
            n_vld[k] = (r_vld[k] && !mv[k]) || ld[k];
        end
    end

    assign n_slot = (r_slot == SLOT_W'(WINDOW - 1)) ? '0 : r_slot + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_slot <= SLOT_W'(WINDOW - 1);
            r_fill <= '0;
        end else begin
            r_vld <= n_vld;
            if (accept) begin
                r_slot <= n_slot;
                if (r_fill != FILL_W'(WINDOW)) begin
                    r_fill <= r_fill + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld[1]) begin
            r_slot1 <= n_slot;
            r_full1 <= (r_fill == FILL_W'(WINDOW));
        end
        if (ld[2]) begin
            r_slot2 <= r_slot1;
            r_full2 <= r_full1;
        end
        if (ld[3]) begin
            r_slot3 <= r_slot2;
            r_full3 <= r_full2;
        end
        if (ld[4]) begin
            r_full4 <= r_full3;
        end
    end

    assign o_in_stall  = r_vld[1] && !mv[1];
    assign o_out_valid = r_vld[STAGES];

    assign o_ctl.ld    = ld;
    assign o_ctl.slot1 = SLOT_MAX_W'(r_slot1);
    assign o_ctl.full2 = r_full2;
    assign o_ctl.slot3 = SLOT_MAX_W'(r_slot3);
    assign o_ctl.full4 = r_full4;

endmodule

FILE: rtl/core/irwn_lane.sv
// One channel lane of the infrared window normalizer: offset and gain,
// saturation, raw and normalized rings with running sums, window averages.
// Depends on irwn_pkg; driven by irwn_ctrl through t_lane_ctl.
module irwn_lane import irwn_pkg::*; #(
    parameter int WINDOW = WINDOW_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_lane_ctl                 i_ctl,
    input  logic [SAMPLE_W-1:0]       i_sample,
    input  logic [SAMPLE_W-1:0]       i_base,
    input  logic signed [SCALE_W-1:0] i_scale,
    output logic signed [NORM_W-1:0]  o_norm,
    output logic signed [NORM_W-1:0]  o_avg_norm,
    output logic [SAMPLE_W-1:0]       o_avg_raw
);

    localparam int SLOT_W  = $clog2(WINDOW);
    localparam int Q_W     = PROD_W - FRAC_SHIFT;

    // Division by the window length is a multiply by a rounded-up
    // reciprocal; the shift leaves enough headroom for an exact quotient.
    localparam int RSUM_W  = $clog2(WINDOW * ((1 << SAMPLE_W) - 1) + 1);
    localparam int RAW_SH  = RSUM_W + SLOT_W;
    localparam int RPROD_W = 2 * RSUM_W + 1;
    localparam logic [RSUM_W:0] RAW_MUL =
        (RSUM_W + 1)'(((64'd1 << RAW_SH) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));

    localparam int NSUM_W  = NORM_W + SLOT_W;
    localparam int NORM_SH = NSUM_W + SLOT_W;
    localparam int NPROD_W = 2 * NSUM_W + 1;
    localparam logic [NSUM_W:0] NORM_MUL =
        (NSUM_W + 1)'(((64'd1 << NORM_SH) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));

    logic [SAMPLE_W-1:0]       r_raw_mem [WINDOW];
    logic signed [NORM_W-1:0]  r_norm_mem [WINDOW];

    logic [SAMPLE_W-1:0]       r_samp1;
    logic signed [DIFF_W-1:0]  r_diff1;
    logic signed [PROD_W-1:0]  r_prod2;
    logic [SAMPLE_W-1:0]       r_samp2;
    logic [SAMPLE_W-1:0]       r_rev2;
    logic [RSUM_W-1:0]         r_raw_acc;
    logic [RSUM_W-1:0]         n_raw_acc;
    logic signed [NORM_W-1:0]  r_norm3;
    logic signed [NORM_W-1:0]  n_norm3;
    logic signed [NORM_W-1:0]  r_nev4;
    logic signed [NORM_W-1:0]  r_norm4;
    logic [SAMPLE_W-1:0]       r_ravg4;
    logic signed [NSUM_W-1:0]  r_norm_acc;
    logic signed [NSUM_W-1:0]  n_norm_acc;
    logic signed [NORM_W-1:0]  r_norm5;
    logic [SAMPLE_W-1:0]       r_ravg5;
    logic signed [NORM_W-1:0]  r_norm6;
    logic [SAMPLE_W-1:0]       r_ravg6;
    logic                      r_nneg6;
    logic [NORM_W-1:0]         r_nq6;
    logic signed [Q_W-1:0]     q_floor;
    logic [RPROD_W-1:0]        raw_prod;
    logic [NSUM_W-1:0]         norm_mag;
    logic [NPROD_W-1:0]        norm_prod;

    // Arithmetic shift of the product rounds toward minus infinity; the
    // value is clamped when its upper bits are not a plain sign extension.
    always_comb begin
        q_floor = r_prod2[PROD_W-1:FRAC_SHIFT];
        if (q_floor[Q_W-1:NORM_W-1] == {(Q_W - NORM_W + 1){q_floor[NORM_W-1]}}) begin
            n_norm3 = q_floor[NORM_W-1:0];
        end else if (q_floor[Q_W-1]) begin
            n_norm3 = NORM_MIN;
        end else begin
            n_norm3 = NORM_MAX;
        end
    end

    // Slots not yet written in the first lap count as zero.
    assign n_raw_acc = r_raw_acc + RSUM_W'(r_samp2)
                     - (i_ctl.full2 ? RSUM_W'(r_rev2) : RSUM_W'(0));
    assign n_norm_acc = r_norm_acc + NSUM_W'(r_norm4)
                      - (i_ctl.full4 ? NSUM_W'(r_nev4) : NSUM_W'(0));

    assign raw_prod  = RPROD_W'(r_raw_acc) * RPROD_W'(RAW_MUL);
    assign norm_mag  = r_norm_acc[NSUM_W-1] ? NSUM_W'(-r_norm_acc) : NSUM_W'(r_norm_acc);
    assign norm_prod = NPROD_W'(norm_mag) * NPROD_W'(NORM_MUL);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_raw_acc  <= '0;
            r_norm_acc <= '0;
        end else begin
            if (i_ctl.ld[3]) begin
                r_raw_acc <= n_raw_acc;
            end
            if (i_ctl.ld[5]) begin
                r_norm_acc <= n_norm_acc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld[1]) begin
            r_samp1 <= i_sample;
            r_diff1 <= $signed({1'b0, i_sample}) - $signed({1'b0, i_base});
        end
        if (i_ctl.ld[2]) begin
            r_prod2 <= PROD_W'(r_diff1) * PROD_W'(i_scale);
            r_samp2 <= r_samp1;
            r_raw_mem[i_ctl.slot1[SLOT_W-1:0]] <= r_samp1;
            r_rev2  <= r_raw_mem[i_ctl.slot1[SLOT_W-1:0]];
        end
        if (i_ctl.ld[3]) begin
            r_norm3 <= n_norm3;
        end
        if (i_ctl.ld[4]) begin
            r_norm_mem[i_ctl.slot3[SLOT_W-1:0]] <= r_norm3;
            r_nev4  <= r_norm_mem[i_ctl.slot3[SLOT_W-1:0]];
            r_norm4 <= r_norm3;
            r_ravg4 <= raw_prod[RAW_SH +: SAMPLE_W];
        end
        if (i_ctl.ld[5]) begin
            r_norm5 <= r_norm4;
            r_ravg5 <= r_ravg4;
        end
        if (i_ctl.ld[6]) begin
            r_norm6 <= r_norm5;
            r_ravg6 <= r_ravg5;
            r_nneg6 <= r_norm_acc[NSUM_W-1];
            r_nq6   <= norm_prod[NORM_SH +: NORM_W];
        end
    end

    // The quotient is of the magnitude, so the sign put back afterward
    // gives truncation toward zero.
    assign o_norm     = r_norm6;
    assign o_avg_raw  = r_ravg6;
    assign o_avg_norm = r_nneg6 ? (NORM_W'(0) - r_nq6) : r_nq6;

endmodule

FILE: rtl/core/ir_window_normalizer.sv
// Infrared window normalizer: offset, gain and window averaging of
// four-channel infrared samples. Top level with configuration registers.
// Depends on irwn_pkg, irwn_ctrl and irwn_lane.
//
// Usage. Each input beat on i_in_data carries one 12-bit sample for each of
// the four channels and is taken at an edge with i_in_valid high and
// o_in_stall low. Every input beat gives exactly one output beat on
// o_out_data, offered with o_out_valid and taken when i_out_stall is low.
// Per channel the block subtracts the baseline, applies the signed Q16
// gain, floors and saturates to 24 bits, and averages the last WINDOW raw
// and normalized values (slots not yet filled count as zero).
// The pipeline has seven register stages, from the input register to the
// result register. Throughput is one beat per cycle while the receiver
// does not stall; the rate is set by the running-sum stages, each of which
// folds one beat per cycle into its accumulator.
// When the receiver stalls, the result register holds its beat and the
// stages behind it keep filling until no bubble is left; only then does
// o_in_stall rise. Reset (synchronous, i_rst_n low) empties the pipeline,
// clears the running sums and the fill count, so ring contents from before
// reset are never read, and returns baselines to 0 and gains to 1.0.
// Registers are written through i_cfg_we, i_cfg_idx and i_cfg_data while
// the block is idle; a write takes effect for the next sample.
module ir_window_normalizer import irwn_pkg::*; #(
    parameter int WINDOW = WINDOW_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_beat              i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_beat             o_out_data,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic [SAMPLE_W-1:0]       r_base  [CH_N];
    logic signed [SCALE_W-1:0] r_scale [CH_N];

    t_lane_ctl                 ctl;
    logic [SAMPLE_W-1:0]       lane_samp     [CH_N];
    logic signed [NORM_W-1:0]  lane_norm     [CH_N];
    logic signed [NORM_W-1:0]  lane_avg_norm [CH_N];
    logic [SAMPLE_W-1:0]       lane_avg_raw  [CH_N];
    t_out_beat                 n_out;
    t_out_beat                 r_out;

    // Configuration registers; baselines keep the low 12 bits of the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < CH_N; c++) begin
                r_base[c]  <= '0;
                r_scale[c] <= SCALE_RESET;
            end
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_BASE_LF:  r_base[0]  <= i_cfg_data[SAMPLE_W-1:0];
                REG_BASE_L:   r_base[1]  <= i_cfg_data[SAMPLE_W-1:0];
                REG_BASE_R:   r_base[2]  <= i_cfg_data[SAMPLE_W-1:0];
                REG_BASE_RF:  r_base[3]  <= i_cfg_data[SAMPLE_W-1:0];
                REG_SCALE_LF: r_scale[0] <= i_cfg_data;
                REG_SCALE_L:  r_scale[1] <= i_cfg_data;
                REG_SCALE_R:  r_scale[2] <= i_cfg_data;
                REG_SCALE_RF: r_scale[3] <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    irwn_ctrl #(
        .WINDOW(WINDOW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_ctl       (ctl)
    );

    assign lane_samp[0] = i_in_data.sample_lf;
    assign lane_samp[1] = i_in_data.sample_l;
    assign lane_samp[2] = i_in_data.sample_r;
    assign lane_samp[3] = i_in_data.sample_rf;

    // Four identical lanes, one for each channel, run in lockstep.
    for (genvar g = 0; g < CH_N; g++) begin : g_lane
        irwn_lane #(
            .WINDOW(WINDOW)
        ) u_lane (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (ctl),
            .i_sample   (lane_samp[g]),
            .i_base     (r_base[g]),
            .i_scale    (r_scale[g]),
            .o_norm     (lane_norm[g]),
            .o_avg_norm (lane_avg_norm[g]),
            .o_avg_raw  (lane_avg_raw[g])
        );
    end

    // The lanes' results are gathered into one output beat.
    always_comb begin
        n_out.norm_lf     = lane_norm[0];
        n_out.norm_l      = lane_norm[1];
        n_out.norm_r      = lane_norm[2];
        n_out.norm_rf     = lane_norm[3];
        n_out.avg_norm_lf = lane_avg_norm[0];
        n_out.avg_norm_l  = lane_avg_norm[1];
        n_out.avg_norm_r  = lane_avg_norm[2];
        n_out.avg_norm_rf = lane_avg_norm[3];
        n_out.avg_raw_lf  = lane_avg_raw[0];
        n_out.avg_raw_l   = lane_avg_raw[1];
        n_out.avg_raw_r   = lane_avg_raw[2];
        n_out.avg_raw_rf  = lane_avg_raw[3];
    end

    always_ff @(posedge i_clk) begin
        if (ctl.ld[STAGES]) begin
            r_out <= n_out;
        end
    end

    assign o_out_data = r_out;

    // Backpressure toward the sender only ever comes from a stalled result.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled without a stalled result");

    // The result register is never overwritten while its beat waits.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.ld[STAGES] |-> (!o_out_valid || !i_out_stall))
        else $error("result register loaded while its beat was stalled");

    // The first stage loads exactly on an accepted input beat.
    a_first_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.ld[1] == (i_in_valid && !o_in_stall))
        else $error("first stage load does not match input acceptance");

endmodule

FILE: test/ir_window_normalizer_test.sv
`timescale 1ns / 100ps
// Self-checking testbench of the infrared window normalizer.
// A directed table and random phases run through the block against a window predictor.
// Depends on irwn_pkg and ir_window_normalizer.
module ir_window_normalizer_test;
    import irwn_pkg::*;

    localparam int WIN          = WINDOW_DEF;
    localparam int HALF_CLK     = 6;
    localparam int RESET_CYCLES = 5;
    // Cycles allowed after the last result before the block counts as idle.
    localparam int SETTLE       = STAGES + 3;
    // Cycles in a row with no beat moving on either channel before the run gives up.
    localparam int STUCK_LIMIT  = 2000;
    localparam int PHASES       = 6;
    localparam int PHASE_ITEMS  = 250;
    localparam int CALM_PHASE   = 2;
    localparam int IDLE_PCT     = 16;
    localparam int REG_COUNT    = 8;
    localparam int OUT_FIELDS   = 12;
    localparam int PRINT_CAP    = 100;

    // Gain patterns of the 30-bit two's complement gain, among them both ends of its range.
    localparam logic [CFG_DATA_W-1:0] GAIN_TOP       = 30'h1FFFFFFF;
    localparam logic [CFG_DATA_W-1:0] GAIN_BOTTOM    = 30'h20000000;
    localparam logic [CFG_DATA_W-1:0] GAIN_MINUS_ONE = 30'h3FFF0000;
    localparam logic [CFG_DATA_W-1:0] GAIN_MINUS_LSB = 30'h3FFFFFFF;
    localparam logic [CFG_DATA_W-1:0] GAIN_QUARTER_K = 30'h10000000;

    typedef enum logic {ROW_CFG, ROW_ITEM} t_row_kind;

    // One row of the directed table: either a register write or a sample beat,
    // the latter optionally with an expected result typed in by hand.
    typedef struct {
        t_row_kind             kind;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
        t_in_beat              smp;
        bit                    typed;
        t_out_beat             want;
    } t_row;

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    t_in_beat              in_data  = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    t_out_beat             out_data;
    logic                  cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx  = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // Predictor copy of the registers, the two rings and the running sums.
    logic [SAMPLE_W-1:0]       base_q       [CH_N];
    logic signed [SCALE_W-1:0] gain_q       [CH_N];
    logic [SAMPLE_W-1:0]       raw_hist     [WIN][CH_N];
    longint                    norm_hist    [WIN][CH_N];
    longint                    raw_total    [CH_N];
    longint                    norm_run_sum [CH_N];
    int                        slot_q;

    t_out_beat pending_q [$];
    t_row      rows [$];
    int        errors    = 0;
    int        out_count = 0;
    int        stuck     = 0;
    bit        calm      = 1'b0;

    string field_names [OUT_FIELDS] = '{
        "norm_lf", "norm_l", "norm_r", "norm_rf",
        "avg_norm_lf", "avg_norm_l", "avg_norm_r", "avg_norm_rf",
        "avg_raw_lf", "avg_raw_l", "avg_raw_r", "avg_raw_rf"
    };

    ir_window_normalizer #(
        .WINDOW (WIN)
    ) dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    always #HALF_CLK clk = ~clk;

    // Works out the result of one sample beat and advances the predictor state.
    // The product is floored by an arithmetic shift, then clamped to 24 bits;
    // the window averages divide by the full window even during warm-up, and
    // the signed division truncates toward zero.
    function automatic t_out_beat predict_window(input t_in_beat b);
        logic [SAMPLE_W-1:0] s [CH_N];
        longint              nv [CH_N];
        longint              p;
        t_out_beat           r;
        s[0] = b.sample_lf;
        s[1] = b.sample_l;
        s[2] = b.sample_r;
        s[3] = b.sample_rf;
        slot_q = (slot_q + 1) % WIN;
        for (int c = 0; c < CH_N; c++) begin
            p = (longint'(s[c]) - longint'(base_q[c])) * longint'(gain_q[c]);
            nv[c] = p >>> FRAC_SHIFT;
            if (nv[c] > longint'(NORM_MAX)) nv[c] = longint'(NORM_MAX);
            if (nv[c] < longint'(NORM_MIN)) nv[c] = longint'(NORM_MIN);
            raw_total[c] += longint'(s[c]) - longint'(raw_hist[slot_q][c]);
            raw_hist[slot_q][c] = s[c];
            norm_run_sum[c] += nv[c] - norm_hist[slot_q][c];
            norm_hist[slot_q][c] = nv[c];
        end
        r.norm_lf     = NORM_W'(nv[0]);
        r.norm_l      = NORM_W'(nv[1]);
        r.norm_r      = NORM_W'(nv[2]);
        r.norm_rf     = NORM_W'(nv[3]);
        r.avg_norm_lf = NORM_W'(norm_run_sum[0] / WIN);
        r.avg_norm_l  = NORM_W'(norm_run_sum[1] / WIN);
        r.avg_norm_r  = NORM_W'(norm_run_sum[2] / WIN);
        r.avg_norm_rf = NORM_W'(norm_run_sum[3] / WIN);
        r.avg_raw_lf  = SAMPLE_W'(raw_total[0] / WIN);
        r.avg_raw_l   = SAMPLE_W'(raw_total[1] / WIN);
        r.avg_raw_r   = SAMPLE_W'(raw_total[2] / WIN);
        r.avg_raw_rf  = SAMPLE_W'(raw_total[3] / WIN);
        return r;
    endfunction

    // Field k of a result beat, widened so that the comparison still sees X and Z.
    function automatic logic signed [63:0] beat_field(input t_out_beat b, input int k);
        case (k)
            0:       return b.norm_lf;
            1:       return b.norm_l;
            2:       return b.norm_r;
            3:       return b.norm_rf;
            4:       return b.avg_norm_lf;
            5:       return b.avg_norm_l;
            6:       return b.avg_norm_r;
            7:       return b.avg_norm_rf;
            8:       return b.avg_raw_lf;
            9:       return b.avg_raw_l;
            10:      return b.avg_raw_r;
            default: return b.avg_raw_rf;
        endcase
    endfunction

    function automatic t_in_beat quad(input logic [SAMPLE_W-1:0] lf, l, r, rf);
        t_in_beat b;
        b.sample_lf = lf;
        b.sample_l  = l;
        b.sample_r  = r;
        b.sample_rf = rf;
        return b;
    endfunction

    // A result with the same values on all four channels, for hand-typed rows.
    function automatic t_out_beat flat_beat(input longint nv, input longint an,
                                            input longint ar);
        t_out_beat r;
        r.norm_lf     = NORM_W'(nv);
        r.norm_l      = NORM_W'(nv);
        r.norm_r      = NORM_W'(nv);
        r.norm_rf     = NORM_W'(nv);
        r.avg_norm_lf = NORM_W'(an);
        r.avg_norm_l  = NORM_W'(an);
        r.avg_norm_r  = NORM_W'(an);
        r.avg_norm_rf = NORM_W'(an);
        r.avg_raw_lf  = SAMPLE_W'(ar);
        r.avg_raw_l   = SAMPLE_W'(ar);
        r.avg_raw_r   = SAMPLE_W'(ar);
        r.avg_raw_rf  = SAMPLE_W'(ar);
        return r;
    endfunction

    function automatic void add_item(input t_in_beat smp, input bit typed,
                                     input t_out_beat want);
        t_row r;
        r.kind  = ROW_ITEM;
        r.idx   = '0;
        r.data  = '0;
        r.smp   = smp;
        r.typed = typed;
        r.want  = want;
        rows.push_back(r);
    endfunction

    function automatic void add_cfg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] data);
        t_row r;
        r.kind  = ROW_CFG;
        r.idx   = idx;
        r.data  = data;
        r.smp   = '0;
        r.typed = 1'b0;
        r.want  = '0;
        rows.push_back(r);
    endfunction

    // Random sample: a share of all-ones as the phase asks, some extremes, some
    // values close to the channel baseline, and the rest spread over all codes.
    function automatic logic [SAMPLE_W-1:0] pick_sample(input logic [SAMPLE_W-1:0] near,
                                                        input int hi_pct);
        int roll;
        roll = $urandom_range(99);
        if (roll < hi_pct) return '1;
        if (roll < hi_pct + 5) return '0;
        if (roll < hi_pct + 10) return '1;
        if (roll < hi_pct + 40) return near + SAMPLE_W'($urandom_range(255)) - SAMPLE_W'(128);
        return SAMPLE_W'($urandom);
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_gain();
        case ($urandom_range(7))
            0:       return GAIN_TOP;
            1:       return GAIN_BOTTOM;
            2:       return CFG_DATA_W'($urandom);
            3:       return '0;
            4:       return GAIN_MINUS_ONE;
            default: return SCALE_RESET + CFG_DATA_W'($urandom_range(262143))
                            - CFG_DATA_W'(131072);
        endcase
    endfunction

    task automatic report_error(input string msg);
        if (errors < PRINT_CAP) $display("ERROR @%0t: %s", $realtime, msg);
        errors++;
    endtask

    task automatic check_beat(input t_out_beat got);
        t_out_beat want;
        if (pending_q.size() == 0) begin
            report_error($sformatf("result %0d arrived with no sample pending", out_count));
        end else begin
            want = pending_q.pop_front();
            for (int k = 0; k < OUT_FIELDS; k++) begin
                if (beat_field(got, k) !== beat_field(want, k))
                    report_error($sformatf("result %0d %s: got %0d, want %0d", out_count,
                                           field_names[k], beat_field(got, k),
                                           beat_field(want, k)));
            end
        end
        out_count++;
    endtask

    // Offers one sample beat, idling first at random unless the calm stretch is
    // on. The call starts and ends on a falling edge; valid stays high into the
    // next call so that back-to-back beats are possible.
    task automatic send_beat(input t_in_beat b, input bit typed, input t_out_beat want);
        t_out_beat predicted;
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= b;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        predicted = predict_window(b);
        pending_q.push_back(typed ? want : predicted);
        @(negedge clk);
    endtask

    // Lets every pending result come out, then gives the pipeline a few more
    // cycles so that nothing is left in flight. If results never come, the
    // watchdog ends the run.
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_q.size() != 0) @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    // Drives one register write for the coming edge. The caller lowers the
    // write enable after the last write of a burst.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        if (idx < REG_SCALE_LF) base_q[idx] = data[SAMPLE_W-1:0];
        else gain_q[idx - REG_SCALE_LF] = data;
        @(negedge clk);
    endtask

    // Writes all eight registers with fresh random values once the block is
    // idle. Baseline writes carry random upper bits, which must be ignored.
    task automatic load_random_setup();
        logic [CFG_DATA_W-1:0] v;
        wait_drained();
        for (int i = 0; i < REG_COUNT; i++) begin
            v = CFG_DATA_W'($urandom);
            if (CFG_IDX_W'(i) < REG_SCALE_LF) begin
                case ($urandom_range(3))
                    0:       v[SAMPLE_W-1:0] = '0;
                    1:       v[SAMPLE_W-1:0] = '1;
                    default: ;
                endcase
            end else begin
                v = pick_gain();
            end
            write_reg(CFG_IDX_W'(i), v);
        end
        cfg_we <= 1'b0;
    endtask

    // The receiver stalls at random, except during the calm stretch.
    always @(negedge clk) begin
        out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
    end

    // Every result beat taken by the receiver is checked against the oldest
    // expectation. Sampling at the rising edge sees the values from before it.
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) check_beat(out_data);
    end

    // Cycles in a row in which no beat moved on either channel.
    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
            stuck <= 0;
        end else begin
            stuck <= stuck + 1;
        end
    end

    initial begin
        while (stuck < STUCK_LIMIT) @(posedge clk);
        $display("TIMEOUT: no beat moved for %0d cycles", stuck);
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        bit writing;
        int hold_at;
        int hi_pct;

        // Predictor state after reset: empty rings, baselines 0, gains 1.0.
        for (int c = 0; c < CH_N; c++) begin
            base_q[c]       = '0;
            gain_q[c]       = SCALE_RESET;
            raw_total[c]    = 0;
            norm_run_sum[c] = 0;
            for (int w = 0; w < WIN; w++) begin
                raw_hist[w][c]  = '0;
                norm_hist[w][c] = 0;
            end
        end
        slot_q  = WIN - 1;
        writing = 1'b0;

        // Right after reset the gain is 1.0 and the baseline 0, so the
        // normalized value equals the sample and both averages are the sample
        // total over the window, counting the empty slots as zero.
        add_item(quad(4095, 4095, 4095, 4095), 1'b1, flat_beat(4095, 255, 255));
        add_item(quad(0, 0, 0, 0), 1'b1, flat_beat(0, 255, 255));
        add_item(quad(16, 16, 16, 16), 1'b1, flat_beat(16, 256, 256));
        add_item(quad(1, 2048, 4094, 2047), 1'b0, '0);

        // Baseline with junk in the upper data bits, largest positive and
        // negative gains for saturation, and a gain of minus one LSB so that a
        // product of -1 shows the floor toward minus infinity.
        add_cfg(REG_BASE_LF, '1);
        add_cfg(REG_BASE_L, 30'd0);
        add_cfg(REG_BASE_R, 30'd2048);
        add_cfg(REG_BASE_RF, 30'd1);
        add_cfg(REG_SCALE_LF, GAIN_TOP);
        add_cfg(REG_SCALE_L, GAIN_BOTTOM);
        add_cfg(REG_SCALE_R, GAIN_MINUS_LSB);
        add_cfg(REG_SCALE_RF, 30'd0);
        add_item(quad(0, 0, 0, 0), 1'b0, '0);
        add_item(quad(4095, 4095, 4095, 4095), 1'b0, '0);
        add_item(quad(4094, 1, 2049, 0), 1'b0, '0);

        // Full baselines with the gains swapped over, so that the clamp is hit
        // from the other side and the averages go strongly negative.
        add_cfg(REG_BASE_LF, 30'd4095);
        add_cfg(REG_BASE_L, 30'd4095);
        add_cfg(REG_BASE_R, 30'd4095);
        add_cfg(REG_BASE_RF, 30'd4095);
        add_cfg(REG_SCALE_LF, GAIN_BOTTOM);
        add_cfg(REG_SCALE_L, GAIN_TOP);
        add_cfg(REG_SCALE_R, GAIN_QUARTER_K);
        add_cfg(REG_SCALE_RF, GAIN_MINUS_ONE);
        add_item(quad(0, 0, 0, 0), 1'b0, '0);
        add_item(quad(0, 4095, 2048, 0), 1'b0, '0);
        add_item(quad(4095, 0, 0, 4095), 1'b0, '0);

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;

        // Walk the directed table. A burst of register writes waits for the
        // block to drain first, and the write enable drops with the next beat.
        foreach (rows[i]) begin
            if (rows[i].kind == ROW_CFG) begin
                if (!writing) wait_drained();
                writing = 1'b1;
                write_reg(rows[i].idx, rows[i].data);
            end else begin
                if (writing) cfg_we <= 1'b0;
                writing = 1'b0;
                send_beat(rows[i].smp, rows[i].typed, rows[i].want);
            end
        end

        // Random phases, each with its own register setting. One phase runs
        // with no idling on either side, one fills the window with full-scale
        // samples, and in every phase the sender stops once at a random point
        // until every pending result has come out.
        for (int p = 0; p < PHASES; p++) begin
            load_random_setup();
            calm    <= (p == CALM_PHASE);
            hi_pct  = (p == PHASES - 2) ? 85 : 0;
            hold_at = $urandom_range(PHASE_ITEMS - 1);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n == hold_at) wait_drained();
                send_beat(quad(pick_sample(base_q[0], hi_pct), pick_sample(base_q[1], hi_pct),
                               pick_sample(base_q[2], hi_pct), pick_sample(base_q[3], hi_pct)),
                          1'b0, '0);
            end
        end

        // A result that never comes keeps this wait open until the watchdog
        // fires; a stray result during the settle cycles is flagged by the check.
        wait_drained();
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/core/irwn_pkg.sv
rtl/core/irwn_ctrl.sv
rtl/core/irwn_lane.sv
rtl/core/ir_window_normalizer.sv
test/ir_window_normalizer_test.sv
